### hdl/bpm_pkg.sv
// Shared types, codes and constants of the buffer pool manager.
package bpm_pkg;

    localparam int DATA_W      = 16;
    localparam int ID_FIELD_W  = 4;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [DATA_W-1:0]  BUFFER_SIZE_RESET = 16'd2048;
    localparam logic [PADDR_W-1:0] ADDR_BUFFER_SIZE  = 3'd0;

    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PREPEND = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CONSUME = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT  = 2'd3;

    // Per-buffer record held in the record memory.
    typedef struct packed {
        logic              in_use;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] length;
    } t_record;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic commit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_ready;
    } t_dp_status;

endpackage

### hdl/buffer_pool_manager.sv
// Top level of the buffer pool manager: controller, datapath and APB register port.
//
// A pool of NUM_BUFFERS packet buffers, handed out from a last-in first-out
// stack of free buffer numbers. Each request on the input channel carries an
// action (allocate, free, reset offset, prepend, consume), a buffer number and
// an amount, and produces exactly one result on the output channel: the
// buffer acted on, a status, its head offset, data length, remaining room
// and whether the pool is exhausted.
// Both channels use valid and stall. A request is taken when i_in_valid is
// high and o_in_stall is low; a result is taken when o_out_valid is high and
// i_out_stall is low.
// A request is handled in order: the free stack and the buffer record are
// read from their memories, then updated, and the result register is
// loaded. A new request is taken only after the last one has loaded the
// result register.
// When the receiver stalls, the result register holds its result and the
// next request is still accepted and read; it waits before committing until
// the result register is empty or its result is being taken.
// After reset a clearing pass refills the free stack and zeroes every buffer
// record; no request is taken during it, while the buffer_size register
// (byte address 0, reset 2048) can be written at any time.
module buffer_pool_manager
    import bpm_pkg::*;
#(
    parameter int NUM_BUFFERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [ID_FIELD_W-1:0] i_buffer_id,
    input  logic [DATA_W-1:0]     i_amount,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ID_FIELD_W-1:0] o_result_buffer,
    output logic [STATUS_W-1:0]   o_status,
    output logic [DATA_W-1:0]     o_head_offset,
    output logic [DATA_W-1:0]     o_data_length,
    output logic [DATA_W-1:0]     o_room,
    output logic                  o_pool_exhausted,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;
    logic       cfg_wr;

    // The port never inserts wait states, so a write lands in its access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    bpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    bpm_datapath #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status_dp      (dp_status),
        .i_action         (i_action),
        .i_buffer_id      (i_buffer_id),
        .i_amount         (i_amount),
        .i_cfg_wr         (cfg_wr),
        .i_cfg_addr       (paddr),
        .i_cfg_wdata      (pwdata),
        .o_cfg_rdata      (prdata),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_result_buffer  (o_result_buffer),
        .o_status         (o_status),
        .o_head_offset    (o_head_offset),
        .o_data_length    (o_data_length),
        .o_room           (o_room),
        .o_pool_exhausted (o_pool_exhausted)
    );

endmodule

### hdl/bpm_ram.sv
// Generic single-write, single-read memory with registered read data.
module bpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/bpm_ctrl.sv
// Controller state machine: clearing pass, request acceptance and commit.
module bpm_ctrl
    import bpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cmd.clear_step = (r_state == S_CLEAR);
    assign o_cmd.accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit     = (r_state == S_EXEC) && i_status.out_ready;

endmodule

### hdl/bpm_datapath.sv
// Datapath: configuration register, free stack, buffer records and result register.
module bpm_datapath
    import bpm_pkg::*;
#(
    parameter int NUM_BUFFERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status_dp,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [ID_FIELD_W-1:0] i_buffer_id,
    input  logic [DATA_W-1:0]     i_amount,
    input  logic                  i_cfg_wr,
    input  logic [PADDR_W-1:0]    i_cfg_addr,
    input  logic [PDATA_W-1:0]    i_cfg_wdata,
    output logic [PDATA_W-1:0]    o_cfg_rdata,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [ID_FIELD_W-1:0] o_result_buffer,
    output logic [STATUS_W-1:0]   o_status,
    output logic [DATA_W-1:0]     o_head_offset,
    output logic [DATA_W-1:0]     o_data_length,
    output logic [DATA_W-1:0]     o_room,
    output logic                  o_pool_exhausted
);

    localparam int ID_W  = $clog2(NUM_BUFFERS);
    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
    localparam int EXT_W = ID_W + ID_FIELD_W;
    localparam int REC_W = $bits(t_record);

    // Configuration register.
    logic [DATA_W-1:0] r_buffer_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUFFER_SIZE_RESET;
        end else if (i_cfg_wr && (i_cfg_addr == ADDR_BUFFER_SIZE)) begin
            r_buffer_size <= i_cfg_wdata[DATA_W-1:0];
        end
    end

    assign o_cfg_rdata = (i_cfg_addr == ADDR_BUFFER_SIZE) ?
                         {{(PDATA_W-DATA_W){1'b0}}, r_buffer_size} : '0;

    // Control registers.
    logic [CNT_W-1:0] r_free_count;
    logic [CNT_W-1:0] n_free_count;
    logic [ID_W-1:0]  r_clr_cnt;
    logic             r_out_valid;

    // Latched request.
    logic [ACTION_W-1:0]   r_action;
    logic [ID_FIELD_W-1:0] r_id;
    logic [DATA_W-1:0]     r_amount;

    // Memory ports.
    logic             stk_wen;
    logic [ID_W-1:0]  stk_waddr;
    logic [ID_W-1:0]  stk_wdata;
    logic [ID_W-1:0]  stk_raddr;
    logic [ID_W-1:0]  stk_rdata;
    logic             rec_wen;
    logic [ID_W-1:0]  rec_waddr;
    logic [REC_W-1:0] rec_wdata;
    logic [ID_W-1:0]  rec_raddr;
    logic [REC_W-1:0] rec_rdata;

    logic [CNT_W-1:0] fc_m1;
    logic [EXT_W-1:0] in_id_ext;

    assign fc_m1     = r_free_count - CNT_W'(1);
    assign in_id_ext = {{ID_W{1'b0}}, i_buffer_id};
    assign stk_raddr = fc_m1[ID_W-1:0];
    assign rec_raddr = in_id_ext[ID_W-1:0];

    bpm_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_BUFFERS)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_wen),
        .i_wr_addr (stk_waddr),
        .i_wr_data (stk_wdata),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (stk_raddr),
        .o_rd_data (stk_rdata)
    );

    bpm_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_BUFFERS)
    ) u_record_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rec_wen),
        .i_wr_addr (rec_waddr),
        .i_wr_data (rec_wdata),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (rec_raddr),
        .o_rd_data (rec_rdata)
    );

    // Execute-cycle evaluation of the latched request.
    t_record               rec;
    logic [EXT_W-1:0]      id_ext;
    logic                  id_ok;
    logic [EXT_W-1:0]      pop_ext;
    logic [ID_W-1:0]       pop_id;
    logic [STATUS_W-1:0]   n_stat;
    logic [ID_FIELD_W-1:0] n_buf;
    logic                  n_use;
    logic [DATA_W-1:0]     n_ofs;
    logic [DATA_W-1:0]     n_len;
    logic                  report;
    logic                  do_rec_wr;
    logic [ID_W-1:0]       tgt_addr;
    logic                  do_push;
    logic [DATA_W-1:0]     n_room;

    always_comb begin
        rec       = t_record'(rec_rdata);
        id_ext    = {{ID_W{1'b0}}, r_id};
        id_ok     = (id_ext < EXT_W'(NUM_BUFFERS));
        pop_ext   = {{ID_FIELD_W{1'b0}}, stk_rdata};
        pop_id    = (pop_ext < EXT_W'(NUM_BUFFERS)) ? stk_rdata : '0;
        n_stat    = ST_OK;
        n_buf     = r_id;
        n_use     = rec.in_use;
        n_ofs     = rec.offset;
        n_len     = rec.length;
        report    = 1'b1;
        do_rec_wr = 1'b0;
        do_push   = 1'b0;
        tgt_addr  = id_ext[ID_W-1:0];
        n_free_count = r_free_count;

        if (r_action == ACT_ALLOC) begin
            if (r_free_count == '0) begin
                n_stat = ST_EMPTY;
                n_buf  = '0;
                report = 1'b0;
            end else begin
                pop_ext      = {{ID_FIELD_W{1'b0}}, pop_id};
                n_buf        = pop_ext[ID_FIELD_W-1:0];
                n_free_count = fc_m1;
                tgt_addr     = pop_id;
                n_use        = 1'b1;
                n_ofs        = '0;
                n_len        = '0;
                do_rec_wr    = 1'b1;
                if (r_amount > r_buffer_size) n_stat = ST_LIMIT;
            end
        end else if (!id_ok) begin
            n_stat = ST_LIMIT;
            report = 1'b0;
        end else begin
            case (r_action)
                ACT_FREE: begin
                    if (!rec.in_use) begin
                        n_stat = ST_DOUBLE;
                    end else begin
                        n_use     = 1'b0;
                        do_rec_wr = 1'b1;
                        if (r_free_count < CNT_W'(NUM_BUFFERS)) begin
                            do_push      = 1'b1;
                            n_free_count = r_free_count + CNT_W'(1);
                        end
                    end
                end
                ACT_RESET: begin
                    if (r_amount >= r_buffer_size) begin
                        n_stat = ST_LIMIT;
                    end else begin
                        n_ofs     = r_amount;
                        n_len     = '0;
                        do_rec_wr = 1'b1;
                    end
                end
                ACT_PREPEND: begin
                    if (r_amount > rec.offset) begin
                        n_stat = ST_LIMIT;
                    end else begin
                        n_ofs     = rec.offset - r_amount;
                        n_len     = rec.length + r_amount;
                        do_rec_wr = 1'b1;
                    end
                end
                ACT_CONSUME: begin
                    if (r_amount > rec.length) begin
                        n_stat = ST_LIMIT;
                    end else begin
                        n_ofs     = rec.offset + r_amount;
                        n_len     = rec.length - r_amount;
                        do_rec_wr = 1'b1;
                    end
                end
                default: begin
                    n_stat = ST_OK;
                end
            endcase
        end

        n_room = (r_buffer_size > n_ofs) ? (r_buffer_size - n_ofs) : '0;
    end

    // Write ports: the clearing pass owns them until it finishes.
    assign stk_wen   = i_cmd.clear_step || (i_cmd.commit && do_push);
    assign stk_waddr = i_cmd.clear_step ? r_clr_cnt : r_free_count[ID_W-1:0];
    assign stk_wdata = i_cmd.clear_step ? r_clr_cnt : id_ext[ID_W-1:0];
    assign rec_wen   = i_cmd.clear_step || (i_cmd.commit && do_rec_wr);
    assign rec_waddr = i_cmd.clear_step ? r_clr_cnt : tgt_addr;
    assign rec_wdata = i_cmd.clear_step ? '0 : {n_use, n_ofs, n_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count <= CNT_W'(NUM_BUFFERS);
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear_step) r_clr_cnt <= r_clr_cnt + ID_W'(1);
            if (i_cmd.commit) begin
                r_free_count <= n_free_count;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_id     <= i_buffer_id;
            r_amount <= i_amount;
        end
        if (i_cmd.commit) begin
            o_result_buffer  <= n_buf;
            o_status         <= n_stat;
            o_head_offset    <= report ? n_ofs : '0;
            o_data_length    <= report ? n_len : '0;
            o_room           <= report ? n_room : '0;
            o_pool_exhausted <= (n_free_count == '0);
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_status_dp.clear_last = (r_clr_cnt == ID_W'(NUM_BUFFERS - 1));
    assign o_status_dp.out_ready  = !r_out_valid || !i_out_stall;

endmodule

### hdl/bpm_checker.sv
// Port-level checks of the buffer pool manager and their binding to the top level.
module bpm_checker
    import bpm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [ID_FIELD_W-1:0] o_result_buffer,
    input logic [STATUS_W-1:0]   o_status,
    input logic [DATA_W-1:0]     o_head_offset,
    input logic [DATA_W-1:0]     o_data_length,
    input logic [DATA_W-1:0]     o_room,
    input logic                  o_pool_exhausted
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status) &&
            $stable(o_result_buffer) && $stable(o_head_offset) &&
            $stable(o_data_length) && $stable(o_room)))
        else $error("stalled result changed");

    // An empty-pool result reports an exhausted pool and no buffer data.
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |->
            (o_pool_exhausted && (o_result_buffer == '0) && (o_head_offset == '0) &&
             (o_data_length == '0) && (o_room == '0)))
        else $error("empty-pool result carries buffer data");

    // One request at a time: the block stalls right after taking a request.
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken without a stall cycle");

    // A result appearing on an empty output comes from an earlier accepted request.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(i_in_valid, 2) && !$past(o_in_stall, 2)))
        else $error("result appeared without a matching request");

endmodule

bind buffer_pool_manager bpm_checker u_bpm_checker (.*);
